@@ src/assert_macros.svh @@
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pee_pkg.sv @@
// Types, codes and constants of the prefix expression evaluator.
package pee_pkg;

  localparam int DATA_W        = 32;
  localparam int STACK_DEPTH_D = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNDER    = 3'd1,
    ST_OVER     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_LEFTOVER = 3'd4,
    ST_DIVZERO  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/prefix_expression_evaluator.sv @@
// Prefix expression evaluator top level: control sequencer, stack and divider.
//
// Usage: characters of one prefix expression arrive on the request channel
// (req_valid, req_stall, req) rightmost first; the leftmost carries last.
// Each request gives at most one response on (rsp_valid, rsp_stall, rsp):
// only the last character of an expression yields value and status.
// A character is taken in S_IDLE, where the stack entry under the top is read,
// and is pushed, popped or combined in S_EXEC. A divide then waits in S_DIV
// for the bit-serial divider, one quotient bit a cycle. The last character
// then loads the response register in S_FIN once that register is free.
// The top of stack sits in a register, the rest in a single-port-read memory,
// so each character needs one read and at most one write.
// Reset (rst, synchronous) empties the stack, clears the error and drops
// rsp_valid; stack contents are left as they are. A stalled response holds
// in its register while further characters are still taken; only the next
// last character waits until the register is free.
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_D
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pee_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pee_pkg::rsp_t rsp
);

  `include "assert_macros.svh"

  localparam int W  = pee_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  pee_pkg::status_t  err;
  logic [W-1:0]      top;
  logic [7:0]        ch;
  logic              last;

  logic              req_take;
  logic              rsp_free;
  logic              is_digit;
  logic              is_op;
  logic [W-1:0]      digit;
  logic              stk_wr_en;
  logic [AW-1:0]     stk_wr_addr;
  logic              stk_rd_en;
  logic [AW-1:0]     stk_rd_addr;
  logic [W-1:0]      stk_rd_data;
  pee_pkg::div_req_t div_req;
  pee_pkg::div_rsp_t div_rsp;
  pee_pkg::status_t  fin_status;

  always_comb begin
    req_stall   = (state != S_IDLE);
    req_take    = req_valid && !req_stall;
    rsp_free    = !rsp_valid || !rsp_stall;
    is_digit    = ch inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]};
    is_op       = ch inside {pee_pkg::CH_ADD, pee_pkg::CH_SUB,
                             pee_pkg::CH_MUL, pee_pkg::CH_DIV};
    digit       = W'(ch - pee_pkg::CH_ZERO);
    stk_rd_en   = req_take;
    stk_rd_addr = AW'(cnt - CW'(2));
    stk_wr_addr = AW'(cnt - CW'(1));
    stk_wr_en   = (state == S_EXEC) && (err == pee_pkg::ST_OK) && is_digit &&
                  (cnt != CW'(STACK_DEPTH)) && (cnt != '0);
    div_req.start    = (state == S_EXEC) && (err == pee_pkg::ST_OK) &&
                       (ch == pee_pkg::CH_DIV) && (cnt >= CW'(2)) &&
                       (stk_rd_data != '0);
    div_req.dividend = top;
    div_req.divisor  = stk_rd_data;
    if (err != pee_pkg::ST_OK) begin
      fin_status = err;
    end else if (cnt == '0) begin
      fin_status = pee_pkg::ST_UNDER;
    end else if (cnt != CW'(1)) begin
      fin_status = pee_pkg::ST_LEFTOVER;
    end else begin
      fin_status = pee_pkg::ST_OK;
    end
  end

  pee_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (top),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  pee_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= pee_pkg::ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_take) begin
            ch    <= req.ch;
            last  <= req.last;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= div_req.start ? S_DIV : (last ? S_FIN : S_IDLE);
          if (err == pee_pkg::ST_OK) begin
            if (is_digit) begin
              if (cnt == CW'(STACK_DEPTH)) begin
                err <= pee_pkg::ST_OVER;
              end else begin
                top <= digit;
                cnt <= cnt + CW'(1);
              end
            end else if (ch == pee_pkg::CH_SPACE) begin
              err <= pee_pkg::ST_OK;
            end else if (!is_op) begin
              err <= pee_pkg::ST_INVALID;
            end else if (cnt < CW'(2)) begin
              err <= pee_pkg::ST_UNDER;
            end else begin
              case (ch)
                pee_pkg::CH_ADD: begin
                  top <= top + stk_rd_data;
                  cnt <= cnt - CW'(1);
                end
                pee_pkg::CH_SUB: begin
                  top <= top - stk_rd_data;
                  cnt <= cnt - CW'(1);
                end
                pee_pkg::CH_MUL: begin
                  top <= top * stk_rd_data;
                  cnt <= cnt - CW'(1);
                end
                default: begin
                  if (stk_rd_data == '0) begin
                    err <= pee_pkg::ST_DIVZERO;
                  end
                end
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            top   <= div_rsp.quotient;
            cnt   <= cnt - CW'(1);
            state <= last ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            rsp.status <= fin_status;
            rsp.value  <= (fin_status == pee_pkg::ST_OK) ? top : '0;
            cnt        <= '0;
            err        <= pee_pkg::ST_OK;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PEE_ASSERT_NOW(a_no_rd_wr_overlap, stk_wr_en, !stk_rd_en, "stack read and write overlap")
  `PEE_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state == S_DIV, "divider done outside divide")
  `PEE_ASSERT_NOW(a_cnt_in_range, state != S_IDLE || !req_take || 1'b1, cnt <= CW'(STACK_DEPTH), "stack count beyond depth")
  `PEE_ASSERT_NEXT(a_fin_clears, state == S_FIN && rsp_free, rsp_valid && cnt == '0 && err == pee_pkg::ST_OK, "end of expression did not clear")
  `PEE_ASSERT_NOW(a_err_value_zero, rsp_valid && rsp.status != pee_pkg::ST_OK, rsp.value == '0, "error response carries a value")

endmodule

@@ src/pee_stack.sv @@
// Operand stack memory: one write port, one read port with registered data.
module pee_stack #(
  parameter int DEPTH = pee_pkg::STACK_DEPTH_D,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [pee_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [pee_pkg::DATA_W-1:0] rd_data
);

  logic [pee_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/pee_divider.sv @@
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
module pee_divider (
  input  logic              clk,
  input  logic              rst,
  input  pee_pkg::div_req_t req,
  output pee_pkg::div_rsp_t rsp
);

  localparam int W  = pee_pkg::DATA_W;
  localparam int SW = $clog2(W);

  logic          running;
  logic          done;
  logic          neg;
  logic [SW-1:0] step;
  logic [W-1:0]  quo;
  logic [W-1:0]  mag_d;
  logic [W:0]    rem;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;

  always_comb begin
    mag_a   = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
    mag_b   = req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
    shifted = {rem[W-1:0], quo[W-1]};
    diff    = shifted - {1'b0, mag_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (req.start) begin
        running <= 1'b1;
        done    <= 1'b0;
        step    <= '0;
        rem     <= '0;
        quo     <= mag_a;
        mag_d   <= mag_b;
        neg     <= req.dividend[W-1] ^ req.divisor[W-1];
      end else if (running) begin
        rem  <= diff[W] ? shifted : diff;
        quo  <= {quo[W-2:0], ~diff[W]};
        step <= step + SW'(1);
        done <= (step == SW'(W - 1));
        if (step == SW'(W - 1)) begin
          running <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? (W'(0) - quo) : quo;

endmodule

@@ tb/sv/prefix_expression_evaluator_test.sv @@
// Self-checking testbench of the prefix expression evaluator: random and directed expressions.
module prefix_expression_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pee_pkg::*;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RSP_STALLS,
    PH_BOTH,
    PH_PRESSURE
  } phase_e;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = 80;
  localparam int          PHASE_ITEMS    = 260;
  localparam logic [7:0]  OP_CHARS [4]   = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t        pending_reqs[$];
  rsp_t        expected_results[$];
  logic [7:0]  expr_chars[$];

  logic [31:0] opnd_stack [STACK_DEPTH_D];
  int          opnd_count    = 0;
  status_t     sticky_status = ST_OK;

  phase_e      phase         = PH_STEADY;
  int          send_gap_pct  = 0;
  int          rsp_stall_pct = 0;
  logic        req_taken     = 1'b0;
  int          hold_left     = 0;
  logic        hold_used     = 1'b0;
  int unsigned quiet_cycles  = 0;
  int          mismatches    = 0;

  prefix_expression_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  task automatic evaluate_char(input req_t r);
    logic [31:0] first_op;
    logic [31:0] second_op;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    logic [31:0] res;
    rsp_t        outcome;
    res = '0;
    if (sticky_status == ST_OK) begin
      if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
        if (opnd_count >= STACK_DEPTH_D) begin
          sticky_status = ST_OVER;
        end else begin
          opnd_stack[opnd_count] = {24'd0, r.ch - CH_ZERO};
          opnd_count++;
        end
      end else if (r.ch != CH_SPACE) begin
        if (r.ch != CH_ADD && r.ch != CH_SUB && r.ch != CH_MUL && r.ch != CH_DIV) begin
          sticky_status = ST_INVALID;
        end else if (opnd_count < 2) begin
          sticky_status = ST_UNDER;
        end else begin
          first_op  = opnd_stack[opnd_count-1];
          second_op = opnd_stack[opnd_count-2];
          case (r.ch)
            CH_ADD: begin
              res = first_op + second_op;
            end
            CH_SUB: begin
              res = first_op - second_op;
            end
            CH_MUL: begin
              res = first_op * second_op;
            end
            default: begin
              if (second_op == '0) begin
                sticky_status = ST_DIVZERO;
              end else begin
                mag_a = first_op[31] ? 32'd0 - first_op : first_op;
                mag_b = second_op[31] ? 32'd0 - second_op : second_op;
                quot  = mag_a / mag_b;
                res   = (first_op[31] ^ second_op[31]) ? 32'd0 - quot : quot;
              end
            end
          endcase
          if (sticky_status == ST_OK) begin
            opnd_count--;
            opnd_stack[opnd_count-1] = res;
          end
        end
      end
    end
    if (r.last) begin
      outcome.value  = '0;
      outcome.status = sticky_status;
      if (sticky_status == ST_OK) begin
        if (opnd_count == 0) begin
          outcome.status = ST_UNDER;
        end else if (opnd_count > 1) begin
          outcome.status = ST_LEFTOVER;
        end else begin
          outcome.value = opnd_stack[0];
        end
      end
      expected_results.push_back(outcome);
      opnd_count    = 0;
      sticky_status = ST_OK;
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic is_last);
    req_t r;
    r.ch   = c;
    r.last = is_last;
    pending_reqs.push_back(r);
  endtask

  // Leftmost character carries last, so send the string back to front.
  task automatic add_expr(input string s);
    for (int i = s.len() - 1; i >= 0; i--) begin
      add_char(s[i], i == 0);
    end
  endtask

  task automatic flush_expr();
    foreach (expr_chars[i]) begin
      add_char(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic put_digit();
    expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Two to the 31st, which wraps to the most negative value.
  task automatic put_pow31();
    repeat (10) expr_chars.push_back(CH_ZERO + 8'd8);
    repeat (9) expr_chars.push_back(CH_MUL);
    expr_chars.push_back(CH_ZERO + 8'd2);
    expr_chars.push_back(CH_MUL);
  endtask

  task automatic put_deep(input int digits, input int ops, input int op_span);
    repeat (digits) put_digit();
    repeat (ops) expr_chars.push_back(OP_CHARS[$urandom_range(0, op_span)]);
  endtask

  task automatic put_wellformed();
    int leaves;
    int placed;
    int depth;
    leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    placed = 0;
    depth  = 0;
    while (placed < leaves || depth > 1) begin
      if (placed < leaves && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        put_digit();
        placed++;
        depth++;
      end else begin
        expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
        depth--;
      end
      if ($urandom_range(0, 9) == 0) expr_chars.push_back(CH_SPACE);
    end
  endtask

  task automatic put_noise();
    int          len;
    logic [7:0]  c;
    len = $urandom_range(1, 6);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(0, 255));
        1: c = CH_ZERO + 8'($urandom_range(0, 9));
        2: c = OP_CHARS[$urandom_range(0, 3)];
        default: c = ($urandom_range(0, 1) == 1) ? CH_SPACE : 8'($urandom_range(0, 255));
      endcase
      expr_chars.push_back(c);
    end
  endtask

  task automatic fill_random(input int n_items);
    int target;
    int pick;
    target = pending_reqs.size() + n_items;
    while (pending_reqs.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 76) begin
        put_wellformed();
      end else if (pick < 77) begin
        put_deep($urandom_range(62, 66), $urandom_range(55, 65), 2);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: begin
            expr_chars.push_back(CH_ZERO + 8'd1);
            expr_chars.push_back(CH_ZERO);
            expr_chars.push_back(CH_SUB);
            put_pow31();
            expr_chars.push_back(CH_DIV);
          end
          1: begin
            expr_chars.push_back(CH_ZERO + 8'd1);
            put_pow31();
            expr_chars.push_back(CH_SUB);
          end
          default: begin
            put_digit();
            put_pow31();
            expr_chars.push_back(CH_DIV);
          end
        endcase
      end else begin
        put_noise();
      end
      flush_expr();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) evaluate_char(req);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Hold off responses for a long stretch once, so that the input backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (phase == PH_PRESSURE && !hold_used && !rst) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= $urandom_range(0, 99) < rsp_stall_pct;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: response with none expected: value %0d status %0d",
                 $time, $signed(rsp.value), rsp.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.value !== want.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d",
                   $time, $signed(want.value), $signed(rsp.value));
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_expr("-27");
    add_expr("*98");
    add_expr("/-092");
    add_expr("/50");
    add_expr("+5");
    add_expr(" ");
    add_expr("12");
    add_expr("x/50");
    add_char(8'h00, 1'b1);
    add_char(8'hff, 1'b1);
    put_deep(65, 0, 0);
    flush_expr();
    put_deep(64, 63, 1);
    flush_expr();

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int p = PH_STEADY; p <= PH_PRESSURE; p++) begin
      phase = phase_e'(p);
      case (phase)
        PH_SEND_GAPS:  begin send_gap_pct = 47; rsp_stall_pct = 0;  end
        PH_RSP_STALLS: begin send_gap_pct = 0;  rsp_stall_pct = 47; end
        PH_BOTH:       begin send_gap_pct = 15; rsp_stall_pct = 15; end
        default:       begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
      endcase
      fill_random(PHASE_ITEMS);
      while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pee_pkg.sv
src/pee_stack.sv
src/pee_divider.sv
src/prefix_expression_evaluator.sv
tb/sv/prefix_expression_evaluator_test.sv
